[rtl/rlepk_pkg.sv]
// Shared constants, types and the color lookup for the run-length pixel row packer.
package rlepk_pkg;

    localparam int ROW_PIXELS_DEF       = 1200;
    localparam int HALF_ROW_BYTES_DEF   = 300;
    localparam int COUNT_FIELD_BITS_DEF = 5;

    localparam int MAX_RESULTS   = 16;
    localparam int RESULT_CNT_W  = $clog2(MAX_RESULTS + 1);
    localparam int PIXEL_W       = 4;
    localparam int BYTE_COL_W    = 9;
    localparam int COLOR_IDX_W   = 3;

    typedef struct packed {
        logic                  emit;
        logic [BYTE_COL_W-1:0] byte_column;
        logic                  half_row_end;
    } step_t;

    function automatic logic [PIXEL_W-1:0] color_lookup(input logic [COLOR_IDX_W-1:0] idx);
        logic [PIXEL_W-1:0] code;
        case (idx)
            3'd0:    code = 4'h0;
            3'd1:    code = 4'h1;
            3'd2:    code = 4'h3;
            3'd3:    code = 4'h2;
            3'd4:    code = 4'h5;
            3'd5:    code = 4'h6;
            3'd6:    code = 4'h0;
            3'd7:    code = 4'h7;
            default: code = 4'h0;
        endcase
        return code;
    endfunction

endpackage

[rtl/rlepk_step.sv]
// Per-pixel step unit: row position advance and half-row byte selection.
module rlepk_step #(
    parameter int ROW_PIXELS     = rlepk_pkg::ROW_PIXELS_DEF,
    parameter int HALF_ROW_BYTES = rlepk_pkg::HALF_ROW_BYTES_DEF,
    parameter int COL_W          = $clog2(ROW_PIXELS)
) (
    input  logic               [COL_W-1:0] col,
    input  logic                           half_select,
    output rlepk_pkg::step_t               step,
    output logic               [COL_W-1:0] col_next
);

    localparam int HB_W = $clog2(2 * HALF_ROW_BYTES + 1);
    localparam int BW   = (COL_W > HB_W) ? COL_W : HB_W;

    logic [BW-1:0]    byte_idx;
    logic [BW-1:0]    base;
    logic [BW-1:0]    diff;
    logic             in_half;
    logic [COL_W:0]   col_inc;

    assign byte_idx = BW'(col[COL_W-1:1]);
    assign base     = half_select ? BW'(HALF_ROW_BYTES) : '0;
    assign diff     = byte_idx - base;
    assign in_half  = (byte_idx >= base) && (byte_idx < base + BW'(HALF_ROW_BYTES));

    assign step.emit         = col[0] && in_half;
    assign step.byte_column  = rlepk_pkg::BYTE_COL_W'(diff);
    assign step.half_row_end = (diff == BW'(HALF_ROW_BYTES - 1));

    assign col_inc  = {1'b0, col} + (COL_W + 1)'(1);
    assign col_next = (col_inc >= (COL_W + 1)'(ROW_PIXELS)) ? '0 : col_inc[COL_W-1:0];

endmodule

[rtl/rle_pixel_row_packer_core.sv]
// Top level of the run-length pixel row packer: stream ports, sequencer, APB register.
//
// Each input beat is a run code (count in the low COUNT_FIELD_BITS bits, color
// index above) that expands into 4-bit pixels packed two per byte along rows
// of ROW_PIXELS pixels; only bytes in the half-row chosen by half_select leave
// as output beats. A single step unit handles one pixel per cycle while the
// output side does not stall, and the next input beat is taken only after a
// run's pixels are stepped and its held byte is flushed. One packed byte
// is held back so the final output beat of a run carries tlast; at most
// MAX_RESULTS beats are sent per run. tlast on the input marks end of image
// and clears the row position and pending nibble after the run.
module rle_pixel_row_packer_core #(
    parameter int ROW_PIXELS       = rlepk_pkg::ROW_PIXELS_DEF,
    parameter int HALF_ROW_BYTES   = rlepk_pkg::HALF_ROW_BYTES_DEF,
    parameter int COUNT_FIELD_BITS = rlepk_pkg::COUNT_FIELD_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] run_byte
    input  logic        s_tlast,   // end_of_image

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] pixel_pair, [16:8] byte_column, [23:17] zero
    output logic        m_tuser,   // [0] half_row_end
    output logic        m_tlast,   // last_of_run

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int COL_W = $clog2(ROW_PIXELS);
    localparam int PW    = rlepk_pkg::PIXEL_W;
    localparam int BCW   = rlepk_pkg::BYTE_COL_W;
    localparam int RCW   = rlepk_pkg::RESULT_CNT_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic                        half_select_reg;
    logic [COL_W-1:0]            col_reg, col_next;
    logic [PW-1:0]               pend_reg, pend_next;
    logic [COUNT_FIELD_BITS-1:0] rem_reg, rem_next;
    logic [PW-1:0]               color_reg;
    logic                        eoi_reg;
    logic [RCW-1:0]              n_reg, n_next;

    logic                        hold_valid_reg, hold_valid_next;
    logic [7:0]                  hold_pair_reg, hold_pair_next;
    logic [BCW-1:0]              hold_col_reg, hold_col_next;
    logic                        hold_end_reg, hold_end_next;

    logic                        out_valid_reg, out_valid_next;
    logic [7:0]                  out_pair_reg;
    logic [BCW-1:0]              out_col_reg;
    logic                        out_end_reg;
    logic                        out_last_reg;
    logic                        push, push_last;

    rlepk_pkg::step_t            step;
    logic [COL_W-1:0]            step_col_next;
    logic                        out_free;
    logic                        emit_sel;
    logic                        in_fire;
    logic                        cfg_wr;
    logic [COUNT_FIELD_BITS-1:0] in_count;
    logic [PW-1:0]               in_color;

    rlepk_step #(
        .ROW_PIXELS     (ROW_PIXELS),
        .HALF_ROW_BYTES (HALF_ROW_BYTES),
        .COL_W          (COL_W)
    ) u_step (
        .col         (col_reg),
        .half_select (half_select_reg),
        .step        (step),
        .col_next    (step_col_next)
    );

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && !paddr[2];
    assign prdata   = paddr[2] ? 32'd0 : {31'd0, half_select_reg};

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign in_count = s_tdata[COUNT_FIELD_BITS-1:0];
    assign in_color = rlepk_pkg::color_lookup(
                          rlepk_pkg::COLOR_IDX_W'(s_tdata >> COUNT_FIELD_BITS));

    assign out_free = !out_valid_reg || m_tready;
    assign emit_sel = step.emit && (n_reg < RCW'(rlepk_pkg::MAX_RESULTS));

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_col_reg, out_pair_reg};
    assign m_tuser  = out_end_reg;
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        col_next        = col_reg;
        pend_next       = pend_reg;
        rem_next        = rem_reg;
        n_next          = n_reg;
        hold_valid_next = hold_valid_reg;
        hold_pair_next  = hold_pair_reg;
        hold_col_next   = hold_col_reg;
        hold_end_next   = hold_end_reg;
        push            = 1'b0;
        push_last       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    rem_next   = in_count;
                    n_next     = '0;
                    state_next = (in_count == '0) ? ST_FLUSH : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!(emit_sel && hold_valid_reg && !out_free))
                begin
                    if (!col_reg[0])
                    begin
                        pend_next = color_reg;
                    end
                    if (emit_sel)
                    begin
                        push            = hold_valid_reg;
                        hold_valid_next = 1'b1;
                        hold_pair_next  = {pend_reg, color_reg};
                        hold_col_next   = step.byte_column;
                        hold_end_next   = step.half_row_end;
                        n_next          = n_reg + RCW'(1);
                    end
                    col_next = step_col_next;
                    rem_next = rem_reg - COUNT_FIELD_BITS'(1);
                    if (rem_reg == COUNT_FIELD_BITS'(1))
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!hold_valid_reg || out_free)
                begin
                    push            = hold_valid_reg;
                    push_last       = 1'b1;
                    hold_valid_next = 1'b0;
                    if (eoi_reg)
                    begin
                        col_next  = '0;
                        pend_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            half_select_reg <= 1'b0;
            col_reg         <= '0;
            pend_reg        <= '0;
            rem_reg         <= '0;
            n_reg           <= '0;
            hold_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            pend_reg       <= pend_next;
            rem_reg        <= rem_next;
            n_reg          <= n_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr)
            begin
                half_select_reg <= pwdata[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hold_pair_reg <= hold_pair_next;
        hold_col_reg  <= hold_col_next;
        hold_end_reg  <= hold_end_next;
        if (in_fire)
        begin
            color_reg <= in_color;
            eoi_reg   <= s_tlast;
        end
        if (push)
        begin
            out_pair_reg <= hold_pair_reg;
            out_col_reg  <= hold_col_reg;
            out_end_reg  <= hold_end_reg;
            out_last_reg <= push_last;
        end
    end

endmodule

[test/tb_top.sv]
// Self-checking testbench for the run-length pixel row packer core.
`timescale 1ns / 1ps

module tb_top;

    localparam int ROW_PIX    = rlepk_pkg::ROW_PIXELS_DEF;
    localparam int HALF_BYTES = rlepk_pkg::HALF_ROW_BYTES_DEF;
    localparam int CNT_BITS   = rlepk_pkg::COUNT_FIELD_BITS_DEF;
    localparam int DRAIN_CYC  = 64;
    localparam int LIMIT_CYC  = 500000;

    localparam logic [2:0] REG_HALF_SELECT = 3'd0;

    // color index to 4-bit pixel code
    localparam logic [rlepk_pkg::PIXEL_W-1:0] PALETTE [8] = '{4'h0, 4'h1, 4'h3, 4'h2,
                                                              4'h5, 4'h6, 4'h0, 4'h7};

    typedef struct packed {
        logic [7:0]                       pixel_pair;
        logic [rlepk_pkg::BYTE_COL_W-1:0] byte_column;
        logic                             half_row_end;
        logic                             last_of_run;
    } packed_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    packed_byte_t     packed_q[$];
    logic [10:0]      pixel_col = '0;
    logic [3:0]       pending_nib = '0;
    logic             half_sel = 1'b0;
    int               errors = 0;
    int               cycles = 0;
    int               idle_pct = 0;
    int               stall_pct = 0;
    int               bytes_predicted = 0;

    rle_pixel_row_packer_core #(
        .ROW_PIXELS       (ROW_PIX),
        .HALF_ROW_BYTES   (HALF_BYTES),
        .COUNT_FIELD_BITS (CNT_BITS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYC)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Expand one run code into the packed bytes it completes in the selected half.
    task automatic expand_run(input logic [7:0] code, input logic eoi);
        int unsigned  count;
        int unsigned  base;
        int unsigned  col;
        int           n;
        logic [3:0]   pix;
        packed_byte_t found [rlepk_pkg::MAX_RESULTS];
        packed_byte_t pb;
        count = code & ((1 << CNT_BITS) - 1);
        pix   = PALETTE[(code >> CNT_BITS) & 7];
        base  = half_sel ? HALF_BYTES : 0;
        n     = 0;
        for (int i = 0; i < count; i++)
        begin
            if (!pixel_col[0])
                pending_nib = pix;
            else
            begin
                col = pixel_col >> 1;
                if (col >= base && col < base + HALF_BYTES && n < rlepk_pkg::MAX_RESULTS)
                begin
                    pb.pixel_pair   = {pending_nib, pix};
                    pb.byte_column  = rlepk_pkg::BYTE_COL_W'(col - base);
                    pb.half_row_end = (col - base == HALF_BYTES - 1);
                    pb.last_of_run  = 1'b0;
                    found[n] = pb;
                    n++;
                end
            end
            pixel_col = (pixel_col + 1 >= ROW_PIX) ? 11'd0 : pixel_col + 11'd1;
        end
        if (n > 0)
            found[n-1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            packed_q.push_back(found[i]);
        bytes_predicted += n;
        if (eoi)
        begin
            pixel_col   = '0;
            pending_nib = '0;
        end
    endtask

    task automatic send_run(input logic [7:0] code, input logic eoi);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        s_tlast  <= eoi;
        do
            @(posedge clk);
        while (!s_tready);
        expand_run(code, eoi);
    endtask

    // Drain all expected beats, then idle the input before the next test.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (packed_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic set_half_select(input logic val);
        logic [31:0] rd;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_HALF_SELECT;
        pwdata  <= {31'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        half_sel = val;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        rd = prdata;
        if (pready !== 1'b1)
        begin
            $error("pready: expected 1, got %b", pready);
            errors++;
        end
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[0] !== val)
        begin
            $error("half_select readback: expected %0d, got %0d", val, rd[0]);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (packed_q.size() == 0)
            begin
                $error("unexpected beat: data %h user %b last %b", m_tdata, m_tuser, m_tlast);
                errors++;
            end
            else
            begin
                automatic packed_byte_t exp_b = packed_q.pop_front();
                if (m_tdata[7:0] !== exp_b.pixel_pair)
                begin
                    $error("pixel_pair: expected %h, got %h", exp_b.pixel_pair, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[16:8] !== exp_b.byte_column)
                begin
                    $error("byte_column: expected %0d, got %0d",
                           exp_b.byte_column, m_tdata[16:8]);
                    errors++;
                end
                if (m_tdata[23:17] !== 7'd0)
                begin
                    $error("tdata pad: expected 0, got %h", m_tdata[23:17]);
                    errors++;
                end
                if (m_tuser !== exp_b.half_row_end)
                begin
                    $error("half_row_end: expected %b, got %b", exp_b.half_row_end, m_tuser);
                    errors++;
                end
                if (m_tlast !== exp_b.last_of_run)
                begin
                    $error("last_of_run: expected %b, got %b", exp_b.last_of_run, m_tlast);
                    errors++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic test_registers();
        set_half_select(1'b1);
        set_half_select(1'b0);
    endtask

    // every color index, zero counts, odd pairing across runs, full-count runs
    task automatic test_palette();
        for (int idx = 0; idx < 8; idx++)
            send_run({3'(idx), 5'd2}, 1'b0);
        send_run(8'h00, 1'b0);
        send_run(8'hE0, 1'b0);
        send_run(8'h21, 1'b0);
        send_run(8'h43, 1'b0);
        send_run(8'hFF, 1'b0);
        send_run(8'h1F, 1'b0);
        settle();
    endtask

    // end of image drops the pending nibble and restarts the row
    task automatic test_end_of_image();
        send_run(8'h65, 1'b1);
        send_run(8'hA1, 1'b0);
        send_run(8'hC3, 1'b0);
        send_run(8'hE0, 1'b1);
        send_run(8'h9F, 1'b0);
        send_run(8'h7F, 1'b1);
        send_run(8'h00, 1'b1);
        send_run(8'hBF, 1'b0);
        settle();
    endtask

    task automatic test_random(input logic half, input int gap, input int stall);
        int          sent;
        int          start_bytes;
        int unsigned count;
        set_half_select(half);
        idle_pct    = gap;
        stall_pct   = stall;
        sent        = 0;
        start_bytes = bytes_predicted;
        while (sent < 24 || bytes_predicted - start_bytes < 24)
        begin
            count = ($urandom_range(99) < 60) ? 31 : $urandom_range(31);
            send_run({3'($urandom_range(7)), 5'(count)}, $urandom_range(63) == 0);
            sent++;
        end
        settle();
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_registers();
        test_palette();
        test_end_of_image();
        test_random(1'b0, 0, 0);
        test_random(1'b1, 78, 0);
        test_random(1'b1, 0, 78);
        test_random(1'b0, 31, 31);
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule

[sim.f]
rtl/rlepk_pkg.sv
rtl/rlepk_step.sv
rtl/rle_pixel_row_packer_core.sv
test/tb_top.sv
